@@ design/cacs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cacs_pkg
// Shared types and constants of the capacity-aware CPU selector.
// ----------------------------------------------------------------------------
package cacs_pkg;

   localparam int CAPACITY_SCALE = 1024;
   localparam int CAP_SHIFT      = $clog2(CAPACITY_SCALE);
   localparam int MAX_CPUS       = 64;
   localparam int CPU_W          = $clog2(MAX_CPUS);

   localparam int CAP_W  = 11;
   localparam int UTIL_W = 11;
   localparam int HARD_W = 12;
   localparam int SUM_W  = 12;
   localparam int EFF_W  = 13;
   localparam int ILAT_W = 16;
   localparam int LAT_W  = 17;
   localparam int DVD_W  = EFF_W + CAP_SHIFT;
   localparam int CNT_W  = $clog2(DVD_W + 1);

   // fits: util * FIT_NUM < cap * FIT_DEN
   localparam int FIT_NUM = 1280;
   localparam int FIT_DEN = 1024;
   localparam int FIT_W   = 24;

   // register map
   localparam int ADDR_W = 5;
   localparam int IDX_W  = 3;
   localparam logic [IDX_W-1:0] REG_LOAD_EST     = 3'd0;
   localparam logic [IDX_W-1:0] REG_UTIL_FLOOR   = 3'd1;
   localparam logic [IDX_W-1:0] REG_WAKER_CPU    = 3'd2;
   localparam logic [IDX_W-1:0] REG_PREVIOUS_CPU = 3'd3;
   localparam logic [IDX_W-1:0] REG_SYNC_WAKE    = 3'd4;
   localparam logic [IDX_W-1:0] REG_WAKER_UTIL   = 3'd5;
   localparam logic [IDX_W-1:0] REG_USE_UTIL_EST = 3'd6;

   localparam logic DIV_REL = 1'b0;
   localparam logic DIV_EFF = 1'b1;

   typedef struct packed {
      logic [UTIL_W-1:0] load_est;
      logic [UTIL_W-1:0] util_floor;
      logic [CPU_W-1:0]  waker_cpu;
      logic [CPU_W-1:0]  previous_cpu;
      logic              sync_wake;
      logic [UTIL_W-1:0] waker_util;
      logic              use_util_est;
   } cfg_type;

   typedef struct packed {
      logic [CPU_W-1:0]  cpu_id;
      logic [CAP_W-1:0]  base_cap;
      logic [CAP_W-1:0]  thermal_load;
      logic [UTIL_W-1:0] cfs_util_avg;
      logic [UTIL_W-1:0] cfs_util_est;
      logic [HARD_W-1:0] other_util;
      logic              cpu_idle;
      logic              single_running;
      logic [ILAT_W-1:0] idle_exit_latency;
      logic              shares_prev_cache;
      logic              is_task_cpu;
      logic              last_candidate;
   } req_type;

   typedef struct packed {
      logic load;
      logic eval;
      logic div_start;
      logic div_sel;
      logic cap_rel;
      logic cap_quo;
      logic commit;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic consider;
      logic last;
      logic div_done;
      logic out_free;
   } sts_type;

endpackage

@@ design/cacs_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cacs_req_if / cacs_rsp_if
// Valid/ready channels for candidate words and result words.
// ----------------------------------------------------------------------------
interface cacs_req_if;
   logic        valid;
   logic        ready;
   logic [5:0]  cpu_id;
   logic [10:0] base_cap;
   logic [10:0] thermal_load;
   logic [10:0] cfs_util_avg;
   logic [10:0] cfs_util_est;
   logic [11:0] other_util;
   logic        cpu_idle;
   logic        single_running;
   logic [15:0] idle_exit_latency;
   logic        shares_prev_cache;
   logic        is_task_cpu;
   logic        last_candidate;

   modport source (output valid, cpu_id, base_cap, thermal_load, cfs_util_avg,
                   cfs_util_est, other_util, cpu_idle, single_running,
                   idle_exit_latency, shares_prev_cache, is_task_cpu,
                   last_candidate, input ready);
   modport sink (input valid, cpu_id, base_cap, thermal_load, cfs_util_avg,
                 cfs_util_est, other_util, cpu_idle, single_running,
                 idle_exit_latency, shares_prev_cache, is_task_cpu,
                 last_candidate, output ready);
endinterface

interface cacs_rsp_if;
   logic       valid;
   logic       ready;
   logic [5:0] chosen_cpu;

   modport source (output valid, chosen_cpu, input ready);
   modport sink (input valid, chosen_cpu, output ready);
endinterface

@@ design/cacs_csr.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cacs_csr
// APB register file holding the waking task's parameters.
// ----------------------------------------------------------------------------
module cacs_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [cacs_pkg::ADDR_W-1:0] paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready,
   output cacs_pkg::cfg_type           cfg
);
   import cacs_pkg::*;

   cfg_type          cfg_ff, cfg_in;
   logic [IDX_W-1:0] idx;
   logic             wr;

   assign idx    = paddr[ADDR_W-1:2];
   assign wr     = psel & penable & pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         unique case (idx)
            REG_LOAD_EST:     cfg_in.load_est     = pwdata[UTIL_W-1:0];
            REG_UTIL_FLOOR:   cfg_in.util_floor   = pwdata[UTIL_W-1:0];
            REG_WAKER_CPU:    cfg_in.waker_cpu    = pwdata[CPU_W-1:0];
            REG_PREVIOUS_CPU: cfg_in.previous_cpu = pwdata[CPU_W-1:0];
            REG_SYNC_WAKE:    cfg_in.sync_wake    = pwdata[0];
            REG_WAKER_UTIL:   cfg_in.waker_util   = pwdata[UTIL_W-1:0];
            REG_USE_UTIL_EST: cfg_in.use_util_est = pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      unique case (idx)
         REG_LOAD_EST:     prdata = 32'(cfg_ff.load_est);
         REG_UTIL_FLOOR:   prdata = 32'(cfg_ff.util_floor);
         REG_WAKER_CPU:    prdata = 32'(cfg_ff.waker_cpu);
         REG_PREVIOUS_CPU: prdata = 32'(cfg_ff.previous_cpu);
         REG_SYNC_WAKE:    prdata = 32'(cfg_ff.sync_wake);
         REG_WAKER_UTIL:   prdata = 32'(cfg_ff.waker_util);
         REG_USE_UTIL_EST: prdata = 32'(cfg_ff.use_util_est);
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{use_util_est: 1'b1, default: '0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end
endmodule

@@ design/cacs_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cacs_div
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cacs_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [cacs_pkg::DVD_W-1:0] dividend,
   input  logic [cacs_pkg::CAP_W-1:0] divisor,
   output logic                       done,
   output logic [cacs_pkg::DVD_W-1:0] quotient
);
   import cacs_pkg::*;

   logic [DVD_W-1:0] dvd_ff, dvd_in;
   logic [CAP_W-1:0] rem_ff, rem_in;
   logic [CAP_W-1:0] dsr_ff, dsr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             done_ff, done_in;
   logic [CAP_W:0]   trial;
   logic             ge;

   assign trial    = {rem_ff, dvd_ff[DVD_W-1]};
   assign ge       = trial >= {1'b0, dsr_ff};
   assign done     = done_ff;
   assign quotient = dvd_ff;

   always_comb begin
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      done_in = done_ff;
      if (start) begin
         dvd_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = CNT_W'(DVD_W);
         done_in = 1'b0;
      end else if (cnt_ff != '0) begin
         // quotient bits shift in where dividend bits leave
         rem_in  = ge ? CAP_W'(trial - {1'b0, dsr_ff}) : trial[CAP_W-1:0];
         dvd_in  = {dvd_ff[DVD_W-2:0], ge};
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end
endmodule

@@ design/cacs_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cacs_dp
// Candidate datapath: derived capacities, utilization, tie-break chain,
// kept best candidate and result register.
// ----------------------------------------------------------------------------
module cacs_dp (
   input  logic                       clock,
   input  logic                       reset,
   input  cacs_pkg::cfg_type          cfg,
   input  cacs_pkg::req_type          req,
   input  cacs_pkg::cmd_type          cmd,
   output cacs_pkg::sts_type          sts,
   input  logic                       rsp_ready,
   output logic                       rsp_valid,
   output logic [cacs_pkg::CPU_W-1:0] rsp_cpu
);
   import cacs_pkg::*;

   req_type           in_ff;
   // candidate
   logic [CAP_W-1:0]  c_cap_max_ff, c_cap_ff, c_cap_nt_ff;
   logic [EFF_W-1:0]  c_eff_ff;
   logic [SUM_W-1:0]  c_util_ff;
   logic [LAT_W-1:0]  c_lat_ff;
   logic [DVD_W-1:0]  c_rel_ff, c_quo_ff;
   logic              take0_ff;
   // kept best
   logic              have_best_ff, have_idle_ff;
   logic [CPU_W-1:0]  b_cpu_ff;
   logic [CAP_W-1:0]  b_cap_max_ff, b_cap_ff;
   logic [EFF_W-1:0]  b_eff_ff;
   logic [DVD_W-1:0]  b_rel_ff, b_quo_ff;
   logic [LAT_W-1:0]  b_lat_ff;
   logic              b_share_ff;
   logic              rsp_valid_ff;
   logic [CPU_W-1:0]  rsp_cpu_ff;

   logic [CAP_W-1:0]  orig, m_orig, cap_max, m_max, cap, cap_nt;
   logic              skip, is_waker, idle, consider, take0, set_idle;
   logic [UTIL_W-1:0] util0, util_s;
   logic [SUM_W-1:0]  util1, util_c;
   logic [EFF_W-1:0]  eff0, eff;
   logic [LAT_W-1:0]  lat;
   logic              div_done;
   logic [DVD_W-1:0]  quotient, dividend;
   logic [CAP_W-1:0]  divisor;
   logic              beats, fit_a, fit_b;
   logic [EFF_W-1:0]  q1_a, q1_b;

   // ---- per-candidate derivation (valid in the eval step)
   always_comb begin
      orig     = (in_ff.base_cap == '0) ? CAP_W'(1) : in_ff.base_cap;
      m_orig   = orig - 1'b1;
      cap_max  = orig - ((in_ff.thermal_load < m_orig) ? in_ff.thermal_load : m_orig);
      m_max    = cap_max - 1'b1;
      cap      = (in_ff.other_util < HARD_W'(m_max)) ?
                 CAP_W'(cap_max - in_ff.other_util[CAP_W-1:0]) : CAP_W'(1);
      cap_nt   = (in_ff.other_util < HARD_W'(m_orig)) ?
                 CAP_W'(orig - in_ff.other_util[CAP_W-1:0]) : CAP_W'(1);
      skip     = have_best_ff && (cap_max < cfg.util_floor) && (cap_max < b_cap_max_ff);
      is_waker = cfg.sync_wake && (in_ff.cpu_id == cfg.waker_cpu);
      idle     = (is_waker && in_ff.single_running) || in_ff.cpu_idle;
      consider = !skip && (idle || !have_idle_ff);
      set_idle = !skip && idle && (cfg.util_floor == '0);
      take0    = !have_best_ff || (set_idle && !have_idle_ff);
      lat      = idle ? LAT_W'(in_ff.idle_exit_latency) + 1'b1 : '0;
      util_s   = (in_ff.cfs_util_avg > cfg.waker_util) ?
                 UTIL_W'(in_ff.cfs_util_avg - cfg.waker_util) : '0;
      util0    = is_waker ? util_s : in_ff.cfs_util_avg;
      if (cfg.use_util_est && (in_ff.cfs_util_est > util0)) util0 = in_ff.cfs_util_est;
      util1    = in_ff.is_task_cpu ? SUM_W'(util0) :
                 SUM_W'(util0) + SUM_W'(cfg.load_est);
      eff0     = EFF_W'(util1) + EFF_W'(in_ff.other_util);
      eff      = (eff0 < EFF_W'(cfg.util_floor)) ? EFF_W'(cfg.util_floor) : eff0;
      util_c   = (util1 < SUM_W'(cfg.util_floor)) ? SUM_W'(cfg.util_floor) : util1;
   end

   // ---- shared divider
   assign dividend = (cmd.div_sel == DIV_REL) ? {EFF_W'(c_util_ff), {CAP_SHIFT{1'b0}}}
                                              : {c_eff_ff, {CAP_SHIFT{1'b0}}};
   assign divisor  = (cmd.div_sel == DIV_REL) ? c_cap_nt_ff : c_cap_max_ff;

   cacs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dividend),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (quotient)
   );

   // ---- tie-break chain, candidate against kept best
   assign q1_a  = c_quo_ff[DVD_W-1:CAP_SHIFT];
   assign q1_b  = b_quo_ff[DVD_W-1:CAP_SHIFT];
   assign fit_a = FIT_W'(cfg.load_est) * FIT_W'(FIT_NUM)
                  < FIT_W'(c_cap_max_ff) * FIT_W'(FIT_DEN);
   assign fit_b = FIT_W'(cfg.load_est) * FIT_W'(FIT_NUM)
                  < FIT_W'(b_cap_max_ff) * FIT_W'(FIT_DEN);

   always_comb begin
      priority if (q1_a != q1_b)
         beats = q1_a < q1_b;
      else if ((b_eff_ff > EFF_W'(b_cap_max_ff)) && (c_eff_ff > EFF_W'(c_cap_max_ff))
               && (c_quo_ff != b_quo_ff))
         beats = c_quo_ff < b_quo_ff;
      else if (fit_a != fit_b)
         beats = fit_a;
      else if (c_rel_ff != b_rel_ff)
         beats = c_rel_ff < b_rel_ff;
      else if ((c_lat_ff != '0) != (b_lat_ff != '0))
         beats = c_lat_ff != '0;
      else if (cfg.sync_wake && (in_ff.cpu_id == cfg.waker_cpu))
         beats = 1'b1;
      else if (cfg.sync_wake && (b_cpu_ff == cfg.waker_cpu))
         beats = 1'b0;
      else if (c_cap_ff != b_cap_ff)
         beats = c_cap_ff > b_cap_ff;
      else if (c_lat_ff != b_lat_ff)
         beats = c_lat_ff < b_lat_ff;
      else if (in_ff.cpu_id == cfg.previous_cpu)
         beats = 1'b1;
      else if (b_cpu_ff == cfg.previous_cpu)
         beats = 1'b0;
      else
         beats = in_ff.shares_prev_cache && !b_share_ff;
   end

   assign sts.consider = consider;
   assign sts.last     = in_ff.last_candidate;
   assign sts.div_done = div_done;
   assign sts.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_cpu      = rsp_cpu_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) in_ff <= req;
      if (cmd.eval) begin
         c_cap_max_ff <= cap_max;
         c_cap_ff     <= cap;
         c_cap_nt_ff  <= cap_nt;
         c_eff_ff     <= eff;
         c_util_ff    <= util_c;
         c_lat_ff     <= lat;
         take0_ff     <= take0;
      end
      if (cmd.cap_rel) c_rel_ff <= quotient;
      if (cmd.cap_quo) c_quo_ff <= quotient;
      if (cmd.commit && (take0_ff || beats)) begin
         b_cpu_ff     <= in_ff.cpu_id;
         b_cap_max_ff <= c_cap_max_ff;
         b_cap_ff     <= c_cap_ff;
         b_eff_ff     <= c_eff_ff;
         b_rel_ff     <= c_rel_ff;
         b_quo_ff     <= c_quo_ff;
         b_lat_ff     <= c_lat_ff;
         b_share_ff   <= in_ff.shares_prev_cache;
      end
      if (cmd.emit) rsp_cpu_ff <= b_cpu_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_best_ff <= 1'b0;
         have_idle_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.eval && set_idle) have_idle_ff <= 1'b1;
         if (cmd.commit && (take0_ff || beats)) have_best_ff <= 1'b1;
         if (cmd.emit) begin
            have_best_ff <= 1'b0;
            have_idle_ff <= 1'b0;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end
endmodule

@@ design/cacs_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cacs_ctrl
// Sequencer: load, evaluate, two divisions, commit, emit.
// ----------------------------------------------------------------------------
module cacs_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  cacs_pkg::sts_type sts,
   output cacs_pkg::cmd_type cmd
);
   import cacs_pkg::*;

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_EVAL     = 3'd1;
   localparam logic [2:0] ST_REL_GO   = 3'd2;
   localparam logic [2:0] ST_REL_WAIT = 3'd3;
   localparam logic [2:0] ST_QUO_GO   = 3'd4;
   localparam logic [2:0] ST_QUO_WAIT = 3'd5;
   localparam logic [2:0] ST_COMMIT   = 3'd6;
   localparam logic [2:0] ST_EMIT     = 3'd7;

   logic [2:0] state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load = req_valid;
            if (req_valid) state_in = ST_EVAL;
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            priority if (sts.consider) state_in = ST_REL_GO;
            else if (sts.last)         state_in = ST_EMIT;
            else                       state_in = ST_IDLE;
         end
         ST_REL_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_REL;
            state_in      = ST_REL_WAIT;
         end
         ST_REL_WAIT: begin
            cmd.cap_rel = sts.div_done;
            if (sts.div_done) state_in = ST_QUO_GO;
         end
         ST_QUO_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_EFF;
            state_in      = ST_QUO_WAIT;
         end
         ST_QUO_WAIT: begin
            cmd.div_sel = DIV_EFF;
            cmd.cap_quo = sts.div_done;
            if (sts.div_done) state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = sts.last ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            cmd.emit = sts.out_free;
            if (sts.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end
endmodule

@@ design/capacity_aware_cpu_selector.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// capacity_aware_cpu_selector
// Picks the best CPU for a waking task from a stream of candidate words.
// ----------------------------------------------------------------------------
// Sequence: a skipped candidate is accepted and evaluated; a considered one
//   is also run through two 23-step divisions in one shared radix-2 divider,
//   each with a start and a wait state, and is then committed. A last
//   candidate then enters the emit state, which holds while the result
//   word is stalled. Candidates are taken one at a time, only when idle.
// Reset clears the selection state, the result valid flag and the registers
//   (use_util_est resets to 1).
module capacity_aware_cpu_selector (
   input  logic                        clock,
   input  logic                        reset,
   cacs_req_if.sink                    req_ch,
   cacs_rsp_if.source                  rsp_ch,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [cacs_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready
);
   import cacs_pkg::*;

   cfg_type cfg;
   req_type req;
   cmd_type cmd;
   sts_type sts;

   assign req.cpu_id            = req_ch.cpu_id;
   assign req.base_cap          = req_ch.base_cap;
   assign req.thermal_load      = req_ch.thermal_load;
   assign req.cfs_util_avg      = req_ch.cfs_util_avg;
   assign req.cfs_util_est      = req_ch.cfs_util_est;
   assign req.other_util        = req_ch.other_util;
   assign req.cpu_idle          = req_ch.cpu_idle;
   assign req.single_running    = req_ch.single_running;
   assign req.idle_exit_latency = req_ch.idle_exit_latency;
   assign req.shares_prev_cache = req_ch.shares_prev_cache;
   assign req.is_task_cpu       = req_ch.is_task_cpu;
   assign req.last_candidate    = req_ch.last_candidate;

   cacs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   cacs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   cacs_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req       (req),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_ready (rsp_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_cpu   (rsp_ch.chosen_cpu)
   );
endmodule

@@ design/cacs_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cacs_chk
// Port-level checks of the selector, bound to the top level.
// ----------------------------------------------------------------------------
module cacs_chk (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [5:0] chosen_cpu
);
   // a held result word does not change
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(chosen_cpu))
      else $error("result word dropped or changed while stalled");

   // one candidate at a time
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("word accepted while previous one in flight");

   // no result can appear the cycle after an accept
   a_no_fast_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("result raised too early");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");
endmodule

bind capacity_aware_cpu_selector cacs_chk u_chk (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .chosen_cpu (rsp_ch.chosen_cpu)
);
